FILE: rtl/kdp_pkg.sv
package kdp_pkg;

	// Coordinate and processor widths are fixed by the register and field formats.
	localparam int COORD_BITS   = 16;
	localparam int PE_BITS      = 10;
	localparam int CFG_IDX_BITS = 3;
	localparam int OUT_COORD_W  = COORD_BITS + 1;
	localparam int OUT_PE_W     = PE_BITS + 1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [PE_BITS-1:0]    pe_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_X_START     = 3'd0,
		REG_X_END       = 3'd1,
		REG_Y_START     = 3'd2,
		REG_Y_END       = 3'd3,
		REG_FIRST_PE    = 3'd4,
		REG_LAST_PE     = 3'd5,
		REG_START_LEVEL = 3'd6
	} kdp_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK_OWN,
		ST_WALK_NB,
		ST_FINISH
	} kdp_state_t;

	// One node of the bisection tree as it sits on the walk stack.
	typedef struct packed {
		coord_t xl;
		coord_t xh;
		coord_t yl;
		coord_t yh;
		pe_t    plo;
		pe_t    phi;
		logic   odd;
	} kdp_node_t;

	typedef struct packed {
		logic push_root;
		logic pop;
		logic split;
	} kdp_stack_ctrl_t;

	typedef struct packed {
		logic clear;
		logic vld;
		logic nb_pass;
	} kdp_leaf_ctrl_t;

	typedef struct packed {
		logic       own_vld;
		coord_t     xl;
		coord_t     xh;
		coord_t     yl;
		coord_t     yh;
		logic [3:0] nb_vld;
		pe_t        nb_left;
		pe_t        nb_right;
		pe_t        nb_down;
		pe_t        nb_up;
	} kdp_result_t;

endpackage

FILE: rtl/kd_domain_partition_lookup_top.sv
// Channel  Direction  Handshake              Payload
// in       receive    in_valid / in_stall    pe_index
// out      send       out_valid / out_stall  own rectangle, four neighbors, too_many_pes
// cfg      receive    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One lookup walks the bisection tree depth first twice, one tree node per
// cycle through a single split unit: the first walk finds the processor's own
// rectangle, the second finds its neighbors. The block takes no new item
// until the result of the walk has moved into the output register; the
// finished result waits there while the next lookup proceeds.
// Reset restores the register defaults and leaves the output channel empty.
module kd_domain_partition_lookup_top import kdp_pkg::*; #(
	parameter int STACK_DEPTH = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [PE_BITS-1:0]             pe_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [OUT_COORD_W-1:0]  own_x_low,
	output logic signed [OUT_COORD_W-1:0]  own_x_high,
	output logic signed [OUT_COORD_W-1:0]  own_y_low,
	output logic signed [OUT_COORD_W-1:0]  own_y_high,
	output logic signed [OUT_PE_W-1:0]     left_neighbor,
	output logic signed [OUT_PE_W-1:0]     right_neighbor,
	output logic signed [OUT_PE_W-1:0]     down_neighbor,
	output logic signed [OUT_PE_W-1:0]     up_neighbor,
	output logic                           too_many_pes,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [COORD_BITS-1:0]          cfg_data
);

	// Configuration registers. Writes are always taken.
	coord_t x_start_q;
	coord_t x_end_q;
	coord_t y_start_q;
	coord_t y_end_q;
	pe_t    first_pe_q;
	pe_t    last_pe_q;
	logic   start_level_q;

	kdp_state_t      state_q;
	kdp_state_t      state_d;
	pe_t             me_q;
	logic            err_q;
	logic            in_xfer;
	logic            nonempty;
	logic            walking;
	logic            is_leaf;
	logic            split_ok;
	logic            overflow;
	logic            empty;
	logic            load_out;
	kdp_node_t       root;
	kdp_node_t       top;
	kdp_node_t       child_a;
	kdp_node_t       child_b;
	kdp_stack_ctrl_t stack_ctrl;
	kdp_leaf_ctrl_t  leaf_ctrl;
	kdp_result_t     result;

	logic                          out_valid_q;
	logic [OUT_COORD_W-1:0]        own_x_low_q;
	logic [OUT_COORD_W-1:0]        own_x_high_q;
	logic [OUT_COORD_W-1:0]        own_y_low_q;
	logic [OUT_COORD_W-1:0]        own_y_high_q;
	logic [OUT_PE_W-1:0]           left_q;
	logic [OUT_PE_W-1:0]           right_q;
	logic [OUT_PE_W-1:0]           down_q;
	logic [OUT_PE_W-1:0]           up_q;
	logic                          too_many_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q     <= COORD_BITS'(0);
			x_end_q       <= COORD_BITS'(127);
			y_start_q     <= COORD_BITS'(0);
			y_end_q       <= COORD_BITS'(127);
			first_pe_q    <= PE_BITS'(0);
			last_pe_q     <= PE_BITS'(31);
			start_level_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_START:     x_start_q     <= cfg_data;
				REG_X_END:       x_end_q       <= cfg_data;
				REG_Y_START:     y_start_q     <= cfg_data;
				REG_Y_END:       y_end_q       <= cfg_data;
				REG_FIRST_PE:    first_pe_q    <= cfg_data[PE_BITS-1:0];
				REG_LAST_PE:     last_pe_q     <= cfg_data[PE_BITS-1:0];
				REG_START_LEVEL: start_level_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The root node covers the whole surface and the whole processor range.
	// An empty range puts nothing on the stack, so both walks end at once.
	assign nonempty = first_pe_q <= last_pe_q;
	assign root     = '{xl: x_start_q, xh: x_end_q, yl: y_start_q, yh: y_end_q,
	                    plo: first_pe_q, phi: last_pe_q, odd: start_level_q};

	assign in_stall = state_q != ST_IDLE;
	assign in_xfer  = in_valid && !in_stall;

	kdp_stack #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (stack_ctrl),
		.root     (root),
		.child_a  (child_a),
		.child_b  (child_b),
		.top      (top),
		.empty    (empty),
		.overflow (overflow)
	);

	kdp_split u_split (
		.node    (top),
		.ok      (split_ok),
		.child_a (child_a),
		.child_b (child_b)
	);

	kdp_leaf u_leaf (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (leaf_ctrl),
		.node   (top),
		.me     (me_q),
		.result (result)
	);

	assign is_leaf  = top.plo == top.phi;
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: each walking cycle takes the top node; it hands a leaf to the
	// leaf unit, splits a node and pushes both parts, or drops an unsplittable one.
	always_comb begin
		state_d              = state_q;
		walking              = 1'b0;
		stack_ctrl.push_root = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					stack_ctrl.push_root = nonempty;
					state_d              = ST_WALK_OWN;
				end
			end
			ST_WALK_OWN: begin
				if (empty) begin
					stack_ctrl.push_root = nonempty;
					state_d              = ST_WALK_NB;
				end else begin
					walking = 1'b1;
				end
			end
			ST_WALK_NB: begin
				if (empty) begin
					state_d = ST_FINISH;
				end else begin
					walking = 1'b1;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		stack_ctrl.pop    = walking && (is_leaf || !split_ok);
		stack_ctrl.split  = walking && !is_leaf && split_ok;
		leaf_ctrl.clear   = in_xfer;
		leaf_ctrl.vld     = walking && is_leaf;
		leaf_ctrl.nb_pass = state_q == ST_WALK_NB;
	end

	// A node that cannot be split, or a part dropped for lack of stack room,
	// marks the whole lookup as failed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (in_xfer) begin
			err_q <= 1'b0;
		end else if ((walking && !is_leaf && !split_ok) || overflow) begin
			err_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			me_q <= pe_index;
		end
	end

	// Output register: the result stays here until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Fields that were never found, or any field of a failed lookup, read -1.
	always_ff @(posedge clk) begin
		if (load_out) begin
			own_x_low_q  <= (result.own_vld && !err_q) ? {1'b0, result.xl} : '1;
			own_x_high_q <= (result.own_vld && !err_q) ? {1'b0, result.xh} : '1;
			own_y_low_q  <= (result.own_vld && !err_q) ? {1'b0, result.yl} : '1;
			own_y_high_q <= (result.own_vld && !err_q) ? {1'b0, result.yh} : '1;
			left_q       <= (result.nb_vld[0] && !err_q) ? {1'b0, result.nb_left} : '1;
			right_q      <= (result.nb_vld[1] && !err_q) ? {1'b0, result.nb_right} : '1;
			down_q       <= (result.nb_vld[2] && !err_q) ? {1'b0, result.nb_down} : '1;
			up_q         <= (result.nb_vld[3] && !err_q) ? {1'b0, result.nb_up} : '1;
			too_many_q   <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign own_x_low      = signed'(own_x_low_q);
	assign own_x_high     = signed'(own_x_high_q);
	assign own_y_low      = signed'(own_y_low_q);
	assign own_y_high     = signed'(own_y_high_q);
	assign left_neighbor  = signed'(left_q);
	assign right_neighbor = signed'(right_q);
	assign down_neighbor  = signed'(down_q);
	assign up_neighbor    = signed'(up_q);
	assign too_many_pes   = too_many_q;

	// A lookup in progress blocks the next input transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while a lookup was still in progress");

	// A failed lookup reports nothing but the flag.
	a_error_blanks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && too_many_pes) |-> (own_x_low == '1 && own_y_high == '1
			&& left_neighbor == '1 && right_neighbor == '1
			&& down_neighbor == '1 && up_neighbor == '1))
		else $error("failed lookup carries a rectangle or a neighbor");

	// Without an own rectangle no neighbor can match.
	a_no_own_no_neighbor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && own_x_low == '1) |-> (left_neighbor == '1
			&& right_neighbor == '1 && down_neighbor == '1 && up_neighbor == '1))
		else $error("neighbor reported for a processor without a rectangle");

endmodule

FILE: rtl/kdp_split.sv
module kdp_split import kdp_pkg::*; (
	input  kdp_node_t node,
	output logic      ok,
	output kdp_node_t child_a,
	output kdp_node_t child_b
);

	logic                xs;
	logic                ys;
	logic                use_y;
	logic                rnd;
	coord_t              lo;
	coord_t              hi;
	logic [COORD_BITS:0] sum;
	coord_t              cut;
	logic [PE_BITS:0]    pe_sum;
	pe_t                 mid;

	// An axis can be split unless its span is exactly one unit.
	assign xs = ({1'b0, node.xl} + (COORD_BITS+1)'(1)) != {1'b0, node.xh};
	assign ys = ({1'b0, node.yl} + (COORD_BITS+1)'(1)) != {1'b0, node.yh};
	assign ok = xs || ys;

	// Odd levels prefer y and round its cut upward; even levels prefer x.
	assign use_y = node.odd ? ys : !xs;
	assign rnd   = use_y && node.odd;
	assign lo    = use_y ? node.yl : node.xl;
	assign hi    = use_y ? node.yh : node.xh;

	// The coordinate adder of the walk, shared by both axes.
	assign sum = {1'b0, lo} + {1'b0, hi} + (COORD_BITS+1)'(rnd);
	assign cut = sum[COORD_BITS:1];

	assign pe_sum = {1'b0, node.plo} + {1'b0, node.phi};
	assign mid    = pe_sum[PE_BITS:1];

	always_comb begin
		child_a     = node;
		child_b     = node;
		child_a.phi = mid;
		child_b.plo = mid + PE_BITS'(1);
		child_a.odd = !node.odd;
		child_b.odd = !node.odd;
		if (use_y) begin
			child_a.yh = cut;
			child_b.yl = cut;
		end else begin
			child_a.xh = cut;
			child_b.xl = cut;
		end
	end

endmodule

FILE: rtl/kdp_stack.sv
module kdp_stack import kdp_pkg::*; #(
	parameter int DEPTH = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kdp_stack_ctrl_t ctrl,
	input  kdp_node_t       root,
	input  kdp_node_t       child_a,
	input  kdp_node_t       child_b,
	output kdp_node_t       top,
	output logic            empty,
	output logic            overflow
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int SP_W  = $clog2(DEPTH + 1);

	kdp_node_t        mem_q [DEPTH];
	logic [SP_W-1:0]  sp_q;
	logic [SP_W-1:0]  sp_m1;
	logic [IDX_W-1:0] top_idx;
	logic [IDX_W-1:0] push_idx;
	logic             room;

	assign sp_m1    = sp_q - SP_W'(1);
	assign top_idx  = sp_m1[IDX_W-1:0];
	assign push_idx = sp_q[IDX_W-1:0];
	assign room     = sp_q < SP_W'(DEPTH);
	assign empty    = sp_q == '0;
	assign top      = mem_q[top_idx];

	// A split replaces the popped node by its second part and pushes the
	// first part above it; with no room left the first part is dropped.
	assign overflow = ctrl.split && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (ctrl.push_root) begin
			sp_q <= SP_W'(1);
		end else if (ctrl.pop) begin
			sp_q <= sp_m1;
		end else if (ctrl.split && room) begin
			sp_q <= sp_q + SP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push_root) begin
			mem_q[0] <= root;
		end else if (ctrl.split) begin
			mem_q[top_idx] <= child_b;
			if (room) begin
				mem_q[push_idx] <= child_a;
			end
		end
	end

endmodule

FILE: rtl/kdp_leaf.sv
module kdp_leaf import kdp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  kdp_leaf_ctrl_t ctrl,
	input  kdp_node_t      node,
	input  pe_t            me,
	output kdp_result_t    result
);

	logic       own_vld_q;
	coord_t     own_xl_q;
	coord_t     own_xh_q;
	coord_t     own_yl_q;
	coord_t     own_yh_q;
	logic [3:0] nb_vld_q;
	pe_t        nb_left_q;
	pe_t        nb_right_q;
	pe_t        nb_down_q;
	pe_t        nb_up_q;
	logic       is_me;
	logic       same_y;
	logic       same_x;
	logic [3:0] hit;

	assign is_me  = node.plo == me;
	assign same_y = (own_yl_q == node.yl) && (own_yh_q == node.yh);
	assign same_x = (own_xl_q == node.xl) && (own_xh_q == node.xh);

	// Neighbor matches only count once the own rectangle is known.
	assign hit[0] = own_vld_q && same_y && (own_xl_q == node.xh);
	assign hit[1] = own_vld_q && same_y && (own_xh_q == node.xl);
	assign hit[2] = own_vld_q && same_x && (own_yl_q == node.yh);
	assign hit[3] = own_vld_q && same_x && (own_yh_q == node.yl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_vld_q <= 1'b0;
			nb_vld_q  <= '0;
		end else if (ctrl.clear) begin
			own_vld_q <= 1'b0;
			nb_vld_q  <= '0;
		end else if (ctrl.vld) begin
			if (is_me && !ctrl.nb_pass) begin
				own_vld_q <= 1'b1;
			end
			if (!is_me && ctrl.nb_pass) begin
				nb_vld_q <= nb_vld_q | hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.vld && is_me && !ctrl.nb_pass) begin
			own_xl_q <= node.xl;
			own_xh_q <= node.xh;
			own_yl_q <= node.yl;
			own_yh_q <= node.yh;
		end
		if (ctrl.vld && !is_me && ctrl.nb_pass) begin
			if (hit[0]) begin
				nb_left_q <= node.plo;
			end
			if (hit[1]) begin
				nb_right_q <= node.plo;
			end
			if (hit[2]) begin
				nb_down_q <= node.plo;
			end
			if (hit[3]) begin
				nb_up_q <= node.plo;
			end
		end
	end

	assign result.own_vld  = own_vld_q;
	assign result.xl       = own_xl_q;
	assign result.xh       = own_xh_q;
	assign result.yl       = own_yl_q;
	assign result.yh       = own_yh_q;
	assign result.nb_vld   = nb_vld_q;
	assign result.nb_left  = nb_left_q;
	assign result.nb_right = nb_right_q;
	assign result.nb_down  = nb_down_q;
	assign result.nb_up    = nb_up_q;

endmodule
